// ===== src/utf8_to_utf16be_converter_defines.svh =====
// assertion macros for the utf-8 to utf-16be converter
`ifndef UTF8_TO_UTF16BE_CONVERTER_DEFINES_SVH
`define UTF8_TO_UTF16BE_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U8U16_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16be converter
package u8u16_pkg;

  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_VAL  = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_VAL  = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_VAL  = 8'hF0;

  localparam logic [20:0] CP_MIN2    = 21'h000080;
  localparam logic [20:0] CP_MAX2    = 21'h0007FF;
  localparam logic [20:0] CP_MIN3    = 21'h000800;
  localparam logic [20:0] SURR_FIRST = 21'h00D800;
  localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;

  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [9:0]  SURR_MASK    = 10'h3FF;

  // index of the final byte in a pack
  localparam logic [1:0]  LAST_ERR  = 2'd0;
  localparam logic [1:0]  LAST_BMP  = 2'd1;
  localparam logic [1:0]  LAST_PAIR = 2'd3;

  // all result bytes caused by one request, byte 0 goes out first
  typedef struct packed {
    logic            err;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } pack_t;

  typedef struct packed {
    logic halted;
    logic pending;
  } dec_stat_t;

endpackage

// ===== src/u8u16_if.sv =====
// handshake channels for utf-8 input bytes and utf-16be result bytes
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_marker;

  modport source (output valid, output in_byte, output end_marker, input ready);
  modport sink   (input valid, input in_byte, input end_marker, output ready);
endinterface

interface u8u16_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       error;
  logic       last_of_run;

  modport source (output valid, output out_byte, output error, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input error, input last_of_run,
                  output ready);
endinterface

// ===== src/u8u16_decode.sv =====
// sequence state and decode of one utf-8 byte into a pack of result bytes
module u8u16_decode
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_marker,
  output logic       pack_valid,
  output pack_t      pack,
  output dec_stat_t  stat
);

  typedef enum logic [1:0] {
    SEQ_NONE,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_FOUR
  } seq_len_t;

  logic [1:0]  rem_r, rem_nxt;
  seq_len_t    seq_r, seq_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        halted_r, halted_nxt;

  logic [20:0] acc_shift;
  logic [1:0]  rem_dec;
  logic        cp_ok;
  logic        emit;
  logic        raise;
  logic [20:0] cp;
  logic [19:0] off;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;

  assign acc_shift = {acc_r[14:0], in_byte[5:0]};
  assign rem_dec   = rem_r - 2'd1;

  always_comb begin
    unique case (seq_r)
      SEQ_TWO:   cp_ok = (acc_shift >= CP_MIN2) && (acc_shift <= CP_MAX2);
      SEQ_THREE: cp_ok = ((acc_shift >= CP_MIN3) && (acc_shift < SURR_FIRST)) ||
                         ((acc_shift > SURR_LAST) && (acc_shift < SUPP_BASE));
      SEQ_FOUR:  cp_ok = (acc_shift >= SUPP_BASE) && (acc_shift <= CP_MAX);
      default:   cp_ok = 1'b0;
    endcase
  end

  always_comb begin
    rem_nxt    = rem_r;
    seq_nxt    = seq_r;
    acc_nxt    = acc_r;
    halted_nxt = halted_r;
    emit       = 1'b0;
    raise      = 1'b0;
    cp         = '0;
    if (!halted_r) begin
      if (end_marker) begin
        raise = (rem_r != 2'd0);
      end else if (rem_r == 2'd0) begin
        if (!in_byte[7]) begin
          emit = 1'b1;
          cp   = {13'd0, in_byte};
        end else if ((in_byte & LEAD2_MASK) == LEAD2_VAL) begin
          seq_nxt = SEQ_TWO;
          rem_nxt = 2'd1;
          acc_nxt = {16'd0, in_byte[4:0]};
        end else if ((in_byte & LEAD3_MASK) == LEAD3_VAL) begin
          seq_nxt = SEQ_THREE;
          rem_nxt = 2'd2;
          acc_nxt = {17'd0, in_byte[3:0]};
        end else if ((in_byte & LEAD4_MASK) == LEAD4_VAL) begin
          seq_nxt = SEQ_FOUR;
          rem_nxt = 2'd3;
          acc_nxt = {18'd0, in_byte[2:0]};
        end else begin
          raise = 1'b1;
        end
      end else if (in_byte[7:6] != 2'b10) begin
        raise = 1'b1;
      end else begin
        acc_nxt = acc_shift;
        rem_nxt = rem_dec;
        if (rem_dec == 2'd0) begin
          seq_nxt = SEQ_NONE;
          acc_nxt = '0;
          if (cp_ok) begin
            emit = 1'b1;
            cp   = acc_shift;
          end else begin
            raise = 1'b1;
          end
        end
      end
    end
    if (raise) begin
      halted_nxt = 1'b1;
      rem_nxt    = 2'd0;
      seq_nxt    = SEQ_NONE;
      acc_nxt    = '0;
    end
  end

  // surrogate pair split for code points above the basic plane
  assign off     = 20'(cp - SUPP_BASE);
  assign hi_unit = HI_SURR_BASE | {6'd0, off[19:10]};
  assign lo_unit = LO_SURR_BASE | {6'd0, off[9:0] & SURR_MASK};

  always_comb begin
    pack = '0;
    if (raise) begin
      pack.err      = 1'b1;
      pack.last_idx = LAST_ERR;
    end else if (cp < SUPP_BASE) begin
      pack.last_idx = LAST_BMP;
      pack.bytes[0] = cp[15:8];
      pack.bytes[1] = cp[7:0];
    end else begin
      pack.last_idx = LAST_PAIR;
      pack.bytes[0] = hi_unit[15:8];
      pack.bytes[1] = hi_unit[7:0];
      pack.bytes[2] = lo_unit[15:8];
      pack.bytes[3] = lo_unit[7:0];
    end
  end

  assign pack_valid  = emit || raise;
  assign stat.halted  = halted_r;
  assign stat.pending = (rem_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= 2'd0;
      seq_r    <= SEQ_NONE;
      acc_r    <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      rem_r    <= rem_nxt;
      seq_r    <= seq_nxt;
      acc_r    <= acc_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ===== src/u8u16_serial.sv =====
// pack register and output register that send a pack one byte per cycle while the receiver is ready
module u8u16_serial
  import u8u16_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pack_load,
  input  pack_t              pack,
  output logic               pack_ready,
  u8u16_out_if.source        out_ch
);

  logic       pack_valid_r, pack_valid_nxt;
  pack_t      pack_r, pack_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_err_r, out_err_nxt;
  logic       out_last_r, out_last_nxt;

  logic out_free;
  logic move;
  logic at_last;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign move       = pack_valid_r && out_free;
  assign at_last    = (idx_r == pack_r.last_idx);
  assign pack_ready = !pack_valid_r || (move && at_last);

  always_comb begin
    pack_valid_nxt = pack_valid_r;
    pack_nxt       = pack_r;
    idx_nxt        = idx_r;
    if (pack_load) begin
      pack_valid_nxt = 1'b1;
      pack_nxt       = pack;
      idx_nxt        = 2'd0;
    end else if (move && at_last) begin
      pack_valid_nxt = 1'b0;
    end else if (move) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pack_r.bytes[idx_r];
      out_err_nxt   = pack_r.err;
      out_last_nxt  = at_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_valid_r <= 1'b0;
      idx_r        <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      pack_valid_r <= pack_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pack_r     <= pack_nxt;
    out_byte_r <= out_byte_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.error       = out_err_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

// ===== src/utf8_to_utf16be_converter.sv =====
// Converts a stream of UTF-8 bytes into UTF-16 big-endian bytes. Each request carries one
// byte or an end marker; a code point below 0x10000 yields two result bytes, a higher one a
// surrogate pair of four bytes, with last_of_run set on the final byte of each request.
// Lead and continuation bytes that do not finish a code point are taken and
// give nothing. Invalid data (bad lead or continuation byte, overlong form, surrogate, value
// above 0x10FFFF, end marker mid-sequence) gives a single result with error set and a zero
// byte; the block then swallows every further request until reset. The output port sends
// one byte per cycle while the receiver is ready; a request yields two bytes for ASCII and
// four for a supplementary character. A new request is taken while the previous
// request's last byte still sits in the output register. No clearing pass after reset.
`include "utf8_to_utf16be_converter_defines.svh"

module utf8_to_utf16be_converter
  import u8u16_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  u8u16_in_if.sink     in_ch,
  u8u16_out_if.source  out_ch
);

  logic      accept;
  logic      pack_valid;
  pack_t     pack;
  logic      pack_ready;
  logic      pack_load;
  dec_stat_t dec_stat;

  assign in_ch.ready = pack_ready;
  assign accept      = in_ch.valid && pack_ready;
  assign pack_load   = accept && pack_valid;

  u8u16_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_ch.in_byte),
    .end_marker (in_ch.end_marker),
    .pack_valid (pack_valid),
    .pack       (pack),
    .stat       (dec_stat)
  );

  u8u16_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .pack_load  (pack_load),
    .pack       (pack),
    .pack_ready (pack_ready),
    .out_ch     (out_ch)
  );

  `U8U16_ASSERT_SAME(a_err_result_shape, out_ch.valid && out_ch.error, out_ch.last_of_run && (out_ch.out_byte == 8'd0), "error result must be a single zero byte")
  `U8U16_ASSERT_SAME(a_err_implies_halted, out_ch.valid && out_ch.error, dec_stat.halted, "error result seen while decoder not halted")
  `U8U16_ASSERT_SAME(a_halted_no_pack, dec_stat.halted, !pack_valid && !dec_stat.pending, "halted decoder still producing or holding a sequence")
  `U8U16_ASSERT_NEXT(a_halted_sticky, dec_stat.halted, dec_stat.halted, "halted state cleared without reset")

endmodule

// ===== verif/utf8_to_utf16be_converter_checker.sv =====
`timescale 1ns / 100ps
// checker that predicts utf-16be result bytes from observed utf-8 requests and compares them
module utf8_to_utf16be_converter_checker
  import u8u16_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  u8u16_in_if   in_ch,
  u8u16_out_if  out_ch,
  output int    mismatch_cnt,
  output int    outstanding,
  output int    checked_cnt
);

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } utf16_byte_t;

  utf16_byte_t utf16_expect_q[$];

  logic [1:0]  cont_left;
  logic [1:0]  seq_len;
  logic [20:0] cp_acc;
  logic        halted;
  int          mism;
  int          checked;

  task automatic push_unit(input logic [15:0] unit, input logic closes);
    utf16_expect_q.push_back(utf16_byte_t'{unit[15:8], 1'b0, 1'b0});
    utf16_expect_q.push_back(utf16_byte_t'{unit[7:0], 1'b0, closes});
  endtask

  task automatic push_code_point(input logic [20:0] cp);
    logic [19:0] ofs;
    ofs = 20'(cp - SUPP_BASE);
    if (cp < SUPP_BASE) begin
      push_unit(cp[15:0], 1'b1);
    end else begin
      // surrogate pair, high half first
      push_unit(HI_SURR_BASE + 16'(ofs[19:10]), 1'b0);
      push_unit(LO_SURR_BASE + 16'(ofs[9:0]), 1'b1);
    end
  endtask

  task automatic halt_with_error();
    halted    = 1'b1;
    cont_left = '0;
    seq_len   = '0;
    cp_acc    = '0;
    utf16_expect_q.push_back(utf16_byte_t'{8'h00, 1'b1, 1'b1});
  endtask

  task automatic predict_utf16(input logic [7:0] b, input logic em);
    logic [20:0] cp;
    logic        ok;
    if (halted) begin
      // sticky error: request swallowed
    end else if (em) begin
      if (cont_left != 0) halt_with_error();
    end else if (cont_left == 0) begin
      if (!b[7]) begin
        push_code_point({13'd0, b});
      end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
        seq_len   = 2'd1;
        cont_left = 2'd1;
        cp_acc    = {16'd0, b[4:0]};
      end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
        seq_len   = 2'd2;
        cont_left = 2'd2;
        cp_acc    = {17'd0, b[3:0]};
      end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
        seq_len   = 2'd3;
        cont_left = 2'd3;
        cp_acc    = {18'd0, b[2:0]};
      end else begin
        halt_with_error();
      end
    end else if (b[7:6] != 2'b10) begin
      halt_with_error();
    end else begin
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 0) begin
        cp = cp_acc;
        case (seq_len)
          2'd1:    ok = cp >= CP_MIN2 && cp <= CP_MAX2;
          2'd2:    ok = cp >= CP_MIN3 && cp < SUPP_BASE &&
                        !(cp >= SURR_FIRST && cp <= SURR_LAST);
          default: ok = cp >= SUPP_BASE && cp <= CP_MAX;
        endcase
        seq_len = '0;
        cp_acc  = '0;
        if (ok) push_code_point(cp);
        else halt_with_error();
      end
    end
  endtask

  always @(posedge clk) begin
    utf16_byte_t want;
    if (!rst_n) begin
      cont_left = '0;
      seq_len   = '0;
      cp_acc    = '0;
      halted    = 1'b0;
      mism      = 0;
      checked   = 0;
      utf16_expect_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) predict_utf16(in_ch.in_byte, in_ch.end_marker);
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (utf16_expect_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected result: byte %02h err %0b last %0b",
                     out_ch.out_byte, out_ch.error, out_ch.last_of_run);
        end else begin
          want = utf16_expect_q.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.error !== want.err ||
              out_ch.last_of_run !== want.last) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: expected byte %02h err %0b last %0b, got byte %02h err %0b last %0b",
                       want.data, want.err, want.last,
                       out_ch.out_byte, out_ch.error, out_ch.last_of_run);
          end
        end
      end
    end
    mismatch_cnt <= mism;
    outstanding  <= utf16_expect_q.size();
    checked_cnt  <= checked;
  end

endmodule

// ===== verif/utf8_to_utf16be_converter_test.sv =====
`timescale 1ns / 100ps
// top of the utf-8 to utf-16be converter testbench: clock, reset, stimulus and verdict
module utf8_to_utf16be_converter_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_UNTIL = 205;

  typedef enum int {
    FAULT_BAD_LEAD,
    FAULT_BAD_CONT,
    FAULT_OVERLONG,
    FAULT_SURROGATE,
    FAULT_ABOVE_RANGE,
    FAULT_END_MID
  } fault_kind_t;

  logic clk;
  logic rst_n;

  u8u16_in_if  in_ch();
  u8u16_out_if out_ch();

  int          mismatch_cnt;
  int          outstanding;
  int          checked_cnt;
  int          sent_cnt = 0;
  int          rand_chars = 0;
  int          burst_left = 0;
  int          cycle_cnt = 0;
  logic [8:0]  stall_phase = '0;
  fault_kind_t fault;

  utf8_to_utf16be_converter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_to_utf16be_converter_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatch_cnt (mismatch_cnt),
    .outstanding  (outstanding),
    .checked_cnt  (checked_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, outstanding);
      $display("utf8_to_utf16be_converter_test failed");
      $finish;
    end
  end

  // receiver stalls: four modes in turn, picked by the top bits of a phase counter
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall_phase <= stall_phase + 9'd1;
      case (stall_phase[8:7])
        2'd0:    out_ch.ready <= 1'b1;
        2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ch.ready <= (stall_phase[4:0] >= 5'd6);
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // one request; valid stays high into the next one unless a gap ends the burst
  task automatic send_item(input logic [7:0] b, input logic em);
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.end_marker <= em;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_cnt++;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [3:0][7:0] utf8_encode(input logic [20:0] cp, input int len);
    logic [3:0][7:0] seq;
    seq = '0;
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    return seq;
  endfunction

  // first n bytes of the len-byte encoding of cp
  task automatic send_prefix(input logic [20:0] cp, input int len, input int n);
    logic [3:0][7:0] seq;
    seq = utf8_encode(cp, len);
    for (int i = 0; i < n; i++) send_item(seq[i], 1'b0);
  endtask

  function automatic logic [20:0] legal_code_point(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        // skip the surrogate block
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= 21'hD800) cp = cp + 21'h800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  task automatic send_random_char();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    rand_chars++;
    if (pick < 8) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      len = (pick < 35) ? 1 : (pick < 55) ? 2 : (pick < 80) ? 3 : 4;
      send_prefix(legal_code_point(len), len, len);
    end
  endtask

  task automatic send_fault(input fault_kind_t kind);
    int len;
    int top;
    len = $urandom_range(2, 4);
    top = (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF;
    case (kind)
      FAULT_BAD_LEAD:
        send_item($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF)) :
                                         8'($urandom_range('hF8, 'hFF)), 1'b0);
      FAULT_BAD_CONT: begin
        send_prefix(legal_code_point(len), len, $urandom_range(1, len - 1));
        send_item($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F)) :
                                         8'($urandom_range('hC0, 'hFF)), 1'b0);
      end
      FAULT_OVERLONG:    send_prefix(21'($urandom_range(0, top)), len, len);
      FAULT_SURROGATE:   send_prefix(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
      FAULT_ABOVE_RANGE: send_prefix(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
      default: begin
        send_prefix(legal_code_point(len), len, $urandom_range(1, len - 1));
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= 8'h00;
    in_ch.end_marker <= 1'b0;
    rst_n            <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // range edges of each sequence length, and an end marker with nothing pending
    send_prefix(21'h000000, 1, 1);
    send_prefix(21'h00007F, 1, 1);
    send_item(8'hFF, 1'b1);
    send_prefix(21'h000080, 2, 2);
    send_prefix(21'h0007FF, 2, 2);
    send_prefix(21'h000800, 3, 3);
    send_prefix(21'h00D7FF, 3, 3);
    send_prefix(21'h00FFFF, 3, 3);
    send_prefix(21'h010000, 4, 4);
    send_prefix(21'h10FFFF, 4, 4);

    while (sent_cnt < RANDOM_UNTIL) send_random_char();

    // the error is sticky, so exactly one fault closes the stream
    fault = fault_kind_t'($urandom_range(0, 5));
    send_fault(fault);
    repeat (15) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent: directed range edges, %0d random characters, closing fault %s",
             sent_cnt, rand_chars, fault.name());
    $display("%0d result bytes checked, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("utf8_to_utf16be_converter_test passed");
    end else begin
      $display("utf8_to_utf16be_converter_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/u8u16_pkg.sv
src/u8u16_if.sv
src/u8u16_decode.sv
src/u8u16_serial.sv
src/utf8_to_utf16be_converter.sv
verif/utf8_to_utf16be_converter_checker.sv
verif/utf8_to_utf16be_converter_test.sv
